// ===== sv/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol table of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int LINE_CHARS_DEF = 72;
	localparam int MAX_CHARS      = 5;
	localparam int CNT_W          = 3;
	localparam int QUEUE_DEPTH    = 2;

	typedef logic [6:0] char_t;

	localparam char_t CHAR_EQ = 7'h3D;
	localparam char_t CHAR_LF = 7'h0A;

	typedef enum logic {
		REG_ALPHABET = 1'b0,
		REG_PAD_WRAP = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	// characters made by one input item, first character in entry 0
	typedef struct packed {
		char_t [MAX_CHARS-1:0] chars;
		logic  [CNT_W-1:0]     n;
		logic                  last;
	} grp_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic char_t sym_ascii(logic [5:0] v, logic url);
		char_t c;
		if (v < 6'd26) begin
			c = 7'(v) + 7'h41;
		end else if (v < 6'd52) begin
			c = 7'(v) + 7'h47;
		end else if (v < 6'd62) begin
			c = 7'(v) - 7'h04;
		end else if (v == 6'd62) begin
			c = url ? 7'h2D : 7'h2B;
		end else begin
			c = url ? 7'h5F : 7'h2F;
		end
		return c;
	endfunction

endpackage

// ===== sv/b64e_if.sv =====
// ----------------------------------------------------------------------------
// b64e interfaces
// Byte, character and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

interface b64e_cfg_if;
	import b64e_pkg::*;
	logic     valid;
	logic     ready;
	cfg_reg_t index;
	logic     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Accept bytes, hold group state and registers, build each byte's characters.
// ----------------------------------------------------------------------------
module b64e_front #(
	parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	b64e_byte_if.sink           byte_in,
	b64e_cfg_if.sink            cfg,
	input  b64e_pkg::q_stat_t   q_stat,
	output logic                push,
	output b64e_pkg::grp_t      grp
);
	import b64e_pkg::*;

	localparam logic [7:0] LC_LIMIT = 8'(LINE_CHARS);

	logic       alpha_q;
	logic       pad_q;
	logic [3:0] carry_q;
	phase_t     phase_q;
	logic [7:0] lc_q;

	logic [3:0] carry_d;
	phase_t     phase_d;
	logic [7:0] lc_d;
	logic [7:0] lc_inc;
	logic [7:0] lc_after;
	logic [7:0] b;
	logic       last;

	assign cfg.ready     = 1'b1;
	assign byte_in.ready = !q_stat.full;
	assign push          = byte_in.valid && byte_in.ready;
	assign b             = byte_in.data_byte;
	assign last          = byte_in.last_byte;
	assign lc_inc        = lc_q + 8'd4;

	always_comb begin
		grp      = '0;
		carry_d  = carry_q;
		phase_d  = phase_q;
		lc_after = lc_q;
		case (phase_q)
			PH_SECOND: begin
				grp.chars[grp.n] = sym_ascii({carry_q[1:0], b[7:4]}, alpha_q);
				grp.n = grp.n + 3'd1;
				carry_d = b[3:0];
				phase_d = PH_THIRD;
				if (last) begin
					grp.chars[grp.n] = sym_ascii({b[3:0], 2'b00}, alpha_q);
					grp.n = grp.n + 3'd1;
					if (pad_q) begin
						grp.chars[grp.n] = CHAR_EQ;
						grp.n = grp.n + 3'd1;
					end
					lc_after = lc_inc;
				end
			end
			PH_THIRD: begin
				grp.chars[grp.n] = sym_ascii({carry_q, b[7:6]}, alpha_q);
				grp.n = grp.n + 3'd1;
				grp.chars[grp.n] = sym_ascii(b[5:0], alpha_q);
				grp.n = grp.n + 3'd1;
				carry_d = '0;
				phase_d = PH_FIRST;
				if (pad_q && lc_inc >= LC_LIMIT) begin
					grp.chars[grp.n] = CHAR_LF;
					grp.n = grp.n + 3'd1;
					lc_after = '0;
				end else begin
					lc_after = lc_inc;
				end
			end
			default: begin
				grp.chars[grp.n] = sym_ascii(b[7:2], alpha_q);
				grp.n = grp.n + 3'd1;
				carry_d = {2'b00, b[1:0]};
				phase_d = PH_SECOND;
				if (last) begin
					grp.chars[grp.n] = sym_ascii({b[1:0], 4'b0000}, alpha_q);
					grp.n = grp.n + 3'd1;
					if (pad_q) begin
						grp.chars[grp.n] = CHAR_EQ;
						grp.n = grp.n + 3'd1;
						grp.chars[grp.n] = CHAR_EQ;
						grp.n = grp.n + 3'd1;
					end
					lc_after = lc_inc;
				end
			end
		endcase
		lc_d = lc_after;
		if (last) begin
			// close a non-empty last line, then start the next message afresh
			if (pad_q && lc_after != 8'd0) begin
				grp.chars[grp.n] = CHAR_LF;
				grp.n = grp.n + 3'd1;
			end
			grp.last = 1'b1;
			carry_d  = '0;
			phase_d  = PH_FIRST;
			lc_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 1'b0;
			pad_q   <= 1'b1;
			carry_q <= '0;
			phase_q <= PH_FIRST;
			lc_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ALPHABET: alpha_q <= cfg.wdata;
					REG_PAD_WRAP: pad_q   <= cfg.wdata;
					default: ;
				endcase
			end
			if (push) begin
				carry_q <= carry_d;
				phase_q <= phase_d;
				lc_q    <= lc_d;
			end
		end
	end

endmodule

// ===== sv/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of character groups between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::grp_t    wr_grp,
	input  logic              pop,
	output b64e_pkg::grp_t    head,
	output b64e_pkg::q_stat_t q_stat
);
	import b64e_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	grp_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Walk head group into output register, one character a cycle unless stalled.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::grp_t    head,
	input  b64e_pkg::q_stat_t q_stat,
	output logic              pop,
	b64e_char_if.source       char_out
);
	import b64e_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             valid_q;
	char_t            char_q;
	logic             last_q;
	logic             load;
	logic             at_end;

	assign load   = !q_stat.empty && (!valid_q || char_out.ready);
	assign at_end = (idx_q == head.n - 3'd1);
	assign pop    = load && at_end;

	assign char_out.valid     = valid_q;
	assign char_out.out_char  = char_q;
	assign char_out.last_char = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.chars[idx_q];
			last_q <= head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? '0 : idx_q + 3'd1;
			end else if (char_out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder with optional '=' padding and line wrap.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in  : one raw byte per item, last_byte flags the end of a message.
//   char_out : one ASCII character per item, last_char on the final one.
//   cfg      : register writes (alphabet_select, pad_and_wrap), always ready;
//              write only while no message is in flight.
// Path: a byte accepted into the group queue has its first character loaded
//   into the output register from the queue head when the queue was empty.
// Throughput: the output register moves one character per cycle while char_out
//   is ready; a byte makes 1 to 5 characters, about 1.4 on average including
//   line feeds. byte_in stays ready while the two-entry group queue has room,
//   so bytes may arrive back to back in bursts.
// Stall: when char_out is held, the output register holds its character,
//   the queue fills and byte_in drops ready; nothing is lost.
// Reset: clears group state, line count, queue and output; registers take
//   standard alphabet and padding with line wrap on.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
	parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	b64e_byte_if.sink    byte_in,
	b64e_cfg_if.sink     cfg,
	b64e_char_if.source  char_out
);
	import b64e_pkg::*;

	// front to queue: one entry per accepted item
	logic    push;
	grp_t    wr_grp;
	// queue to back: head entry and fill status
	logic    pop;
	grp_t    head;
	q_stat_t q_stat;

	// classify bytes and build their characters
	b64e_front #(
		.LINE_CHARS (LINE_CHARS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.cfg     (cfg),
		.q_stat  (q_stat),
		.push    (push),
		.grp     (wr_grp)
	);

	// decouple front and back so that each can stall on its own
	b64e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// serialise characters into the output register
	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.char_out (char_out)
	);

endmodule

// ===== sv/b64e_checker.sv =====
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the output channel of the encoder.
// ----------------------------------------------------------------------------
module b64e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       out_last
);
	import b64e_pkg::*;

	// no character while in reset: the edge after a reset edge shows no item
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("char_out valid during reset");

	// a stalled character stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("char_out valid dropped without acceptance");

	// a stalled character holds its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
		else $error("char_out payload changed while stalled");

	// only alphabet symbols, padding or line feed come out
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_char >= 7'h41 && out_char <= 7'h5A) ||
			(out_char >= 7'h61 && out_char <= 7'h7A) ||
			(out_char >= 7'h30 && out_char <= 7'h39) ||
			out_char == 7'h2B || out_char == 7'h2F ||
			out_char == 7'h2D || out_char == 7'h5F ||
			out_char == CHAR_EQ || out_char == CHAR_LF)
		else $error("char_out carries an illegal character");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (char_out.valid),
	.out_ready (char_out.ready),
	.out_char  (char_out.out_char),
	.out_last  (char_out.last_char)
);
